// ----- src/pes_pkg.sv -----
// Shared types and constants for the particle ellipsoid shape pipeline.
package pes_pkg;

  localparam int ROOT_STAGES = 32;
  localparam int QUO_STAGES  = 32;
  localparam int DATA_W      = 32;
  localparam int WIDE_W      = 64;
  localparam logic [31:0] AXIS_ONE = 32'h4000_0000;

  typedef enum logic [2:0] {
    REG_RADIUS_SCALE  = 3'd0,
    REG_TIME_STEP     = 3'd1,
    REG_VEL_SCALING   = 3'd2,
    REG_KEEP_VOLUME   = 3'd3,
    REG_MIN_SPEED_SQ  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] radius;
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic [31:0] mag_z;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
    logic        ellipsoid;
  } front_t;

  typedef struct packed {
    logic [31:0] major;
    logic [31:0] radius;
    logic        ellipsoid;
  } vol_t;

  typedef struct packed {
    logic [31:0] major;
    logic [31:0] radius;
    logic        ellipsoid;
    logic [31:0] quo_x;
    logic [31:0] quo_y;
    logic [31:0] quo_z;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
  } back_t;

endpackage

// ----- src/pes_sqrt.sv -----
// Pipelined integer square root of a 64-bit value, one root bit per stage.
module pes_sqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   rad_i,
  input  logic [SW-1:0] side_i,
  output logic [31:0]   root_o,
  output logic [SW-1:0] side_o
);

  localparam int STG = pes_pkg::ROOT_STAGES;

  logic [33:0]   rem_r  [STG];
  logic [31:0]   root_r [STG];
  logic [63:0]   rad_r  [STG];
  logic [SW-1:0] side_r [STG];

  genvar g;
  for (g = 0; g < STG; g++) begin : g_stage
    logic [33:0]   rem_p;
    logic [31:0]   root_p;
    logic [63:0]   rad_p;
    logic [SW-1:0] side_p;
    logic [35:0]   cur;
    logic [35:0]   trial;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign side_p = side_i;
    end else begin : g_next
      assign rem_p  = rem_r[g-1];
      assign root_p = root_r[g-1];
      assign rad_p  = rad_r[g-1];
      assign side_p = side_r[g-1];
    end

    assign cur   = {rem_p, rad_p[63:62]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? 34'(cur - trial) : cur[33:0];
        root_r[g] <= {root_p[30:0], ge};
        rad_r[g]  <= {rad_p[61:0], 2'b00};
        side_r[g] <= side_p;
      end
    end
  end

  assign root_o = root_r[STG-1];
  assign side_o = side_r[STG-1];

endmodule

// ----- src/pes_div.sv -----
// Pipelined restoring divider, 64-bit dividend over 32-bit divisor, 32-bit quotient.
module pes_div #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   num_i,
  input  logic [31:0]   den_i,
  input  logic [SW-1:0] side_i,
  output logic [31:0]   quo_o,
  output logic [SW-1:0] side_o
);

  localparam int STG = pes_pkg::QUO_STAGES;

  logic [31:0]   rem_r  [STG];
  logic [31:0]   quo_r  [STG];
  logic [31:0]   low_r  [STG];
  logic [31:0]   den_r  [STG];
  logic [SW-1:0] side_r [STG];

  genvar g;
  for (g = 0; g < STG; g++) begin : g_stage
    logic [31:0]   rem_p;
    logic [31:0]   quo_p;
    logic [31:0]   low_p;
    logic [31:0]   den_p;
    logic [SW-1:0] side_p;
    logic [32:0]   cur;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_p  = num_i[63:32];
      assign quo_p  = '0;
      assign low_p  = num_i[31:0];
      assign den_p  = den_i;
      assign side_p = side_i;
    end else begin : g_next
      assign rem_p  = rem_r[g-1];
      assign quo_p  = quo_r[g-1];
      assign low_p  = low_r[g-1];
      assign den_p  = den_r[g-1];
      assign side_p = side_r[g-1];
    end

    assign cur = {rem_p, low_p[31]};
    assign ge  = (cur >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? 32'(cur - {1'b0, den_p}) : cur[31:0];
        quo_r[g]  <= {quo_p[30:0], ge};
        low_r[g]  <= {low_p[30:0], 1'b0};
        den_r[g]  <= den_p;
        side_r[g] <= side_p;
      end
    end
  end

  assign quo_o  = quo_r[STG-1];
  assign side_o = side_r[STG-1];

endmodule

// ----- src/particle_ellipsoid_shape_core.sv -----
// Top level of the particle ellipsoid shape pipeline.
// An accepted input transaction passes through 103 register stages to its result.
// Throughput is one transaction per cycle unless the output stalls; the two 32-stage root units and the
// four 32-stage dividers are fully pipelined and a stall freezes every stage.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults.
module particle_ellipsoid_shape_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_particle_radius,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_radius_major,
  output logic [31:0]        out_radius_minor,
  output logic signed [31:0] out_axis_x,
  output logic signed [31:0] out_axis_y,
  output logic signed [31:0] out_axis_z,
  output logic               out_is_ellipsoid
);

  localparam int LAT = 3 + pes_pkg::ROOT_STAGES + 2 + pes_pkg::QUO_STAGES + 1 +
                       pes_pkg::ROOT_STAGES + 1;

  logic [31:0] radius_scale_r;
  logic [31:0] time_step_r;
  logic        vel_scaling_r;
  logic        keep_volume_r;
  logic [63:0] min_speed_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_scale_r <= 32'd65536;
      time_step_r    <= '0;
      vel_scaling_r  <= 1'b1;
      keep_volume_r  <= 1'b0;
      min_speed_sq_r <= 64'd43;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pes_pkg::REG_RADIUS_SCALE: radius_scale_r <= cfg_data[31:0];
        pes_pkg::REG_TIME_STEP:    time_step_r    <= cfg_data[31:0];
        pes_pkg::REG_VEL_SCALING:  vel_scaling_r  <= cfg_data[0];
        pes_pkg::REG_KEEP_VOLUME:  keep_volume_r  <= cfg_data[0];
        pes_pkg::REG_MIN_SPEED_SQ: min_speed_sq_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic           adv;
  logic [LAT-1:0] v_r;

  assign adv       = !v_r[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  // Stage 1: radius product and velocity magnitudes.
  logic [63:0] rprod_s1_r;
  logic [31:0] mx_s1_r, my_s1_r, mz_s1_r;
  logic        nx_s1_r, ny_s1_r, nz_s1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rprod_s1_r <= 64'(in_particle_radius) * 64'(radius_scale_r);
      mx_s1_r    <= in_vel_x[31] ? (~$unsigned(in_vel_x) + 32'd1) : $unsigned(in_vel_x);
      my_s1_r    <= in_vel_y[31] ? (~$unsigned(in_vel_y) + 32'd1) : $unsigned(in_vel_y);
      mz_s1_r    <= in_vel_z[31] ? (~$unsigned(in_vel_z) + 32'd1) : $unsigned(in_vel_z);
      nx_s1_r    <= in_vel_x[31];
      ny_s1_r    <= in_vel_y[31];
      nz_s1_r    <= in_vel_z[31];
    end
  end

  // Stage 2: saturated radius and squares.
  logic [31:0] r_s2_r;
  logic [63:0] sqx_s2_r, sqy_s2_r, sqz_s2_r;
  logic [31:0] mx_s2_r, my_s2_r, mz_s2_r;
  logic        nx_s2_r, ny_s2_r, nz_s2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      r_s2_r   <= (|rprod_s1_r[63:48]) ? '1 : rprod_s1_r[47:16];
      sqx_s2_r <= 64'(mx_s1_r) * 64'(mx_s1_r);
      sqy_s2_r <= 64'(my_s1_r) * 64'(my_s1_r);
      sqz_s2_r <= 64'(mz_s1_r) * 64'(mz_s1_r);
      mx_s2_r  <= mx_s1_r;
      my_s2_r  <= my_s1_r;
      mz_s2_r  <= mz_s1_r;
      nx_s2_r  <= nx_s1_r;
      ny_s2_r  <= ny_s1_r;
      nz_s2_r  <= nz_s1_r;
    end
  end

  // Stage 3: squared speed.
  logic [63:0]     s2_s3_r;
  pes_pkg::front_t front_s3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_s3_r              <= sqx_s2_r + sqy_s2_r + sqz_s2_r;
      front_s3_r.radius    <= r_s2_r;
      front_s3_r.mag_x     <= mx_s2_r;
      front_s3_r.mag_y     <= my_s2_r;
      front_s3_r.mag_z     <= mz_s2_r;
      front_s3_r.neg_x     <= nx_s2_r;
      front_s3_r.neg_y     <= ny_s2_r;
      front_s3_r.neg_z     <= nz_s2_r;
      front_s3_r.ellipsoid <= 1'b0;
    end
  end

  pes_pkg::front_t front_in, front_out;
  logic [31:0]     speed;

  always_comb begin
    front_in           = front_s3_r;
    front_in.ellipsoid = (s2_s3_r > min_speed_sq_r);
  end

  pes_sqrt #(.SW($bits(pes_pkg::front_t))) u_speed_sqrt (
    .clk    (clk),
    .en     (adv),
    .rad_i  (s2_s3_r),
    .side_i (front_in),
    .root_o (speed),
    .side_o (front_out)
  );

  // Stage 5: stretch product and radius square.
  logic [63:0]     tsprod_s5_r, rr_s5_r;
  logic [31:0]     speed_s5_r;
  pes_pkg::front_t front_s5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      tsprod_s5_r <= 64'(time_step_r) * 64'(speed);
      rr_s5_r     <= 64'(front_out.radius) * 64'(front_out.radius);
      speed_s5_r  <= speed;
      front_s5_r  <= front_out;
    end
  end

  // Stage 6: major radius.
  logic [47:0] stretch;
  logic [33:0] triple;
  logic [31:0] major_nxt;

  assign stretch = 48'(front_s5_r.radius) + 48'(tsprod_s5_r[63:17]);
  assign triple  = 34'(front_s5_r.radius) + 34'({front_s5_r.radius, 1'b0});

  always_comb begin
    if (vel_scaling_r) begin
      major_nxt = (|stretch[47:32]) ? '1 : stretch[31:0];
    end else begin
      major_nxt = (|triple[33:32]) ? '1 : triple[31:0];
    end
  end

  logic [31:0]     major_s6_r, speed_s6_r;
  logic [63:0]     rr_s6_r;
  pes_pkg::front_t front_s6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      major_s6_r <= major_nxt;
      speed_s6_r <= speed_s5_r;
      rr_s6_r    <= rr_s5_r;
      front_s6_r <= front_s5_r;
    end
  end

  pes_pkg::vol_t vol_in, vol_out;
  logic [31:0]   quo_v, quo_x, quo_y, quo_z;
  logic          neg_x_d, neg_y_d, neg_z_d;

  assign vol_in.major     = major_s6_r;
  assign vol_in.radius    = front_s6_r.radius;
  assign vol_in.ellipsoid = front_s6_r.ellipsoid;

  pes_div #(.SW($bits(pes_pkg::vol_t))) u_vol_div (
    .clk (clk), .en (adv),
    .num_i (rr_s6_r), .den_i (major_s6_r), .side_i (vol_in),
    .quo_o (quo_v), .side_o (vol_out)
  );

  pes_div #(.SW(1)) u_axis_x_div (
    .clk (clk), .en (adv),
    .num_i ({2'b00, front_s6_r.mag_x, 30'd0}), .den_i (speed_s6_r),
    .side_i (front_s6_r.neg_x), .quo_o (quo_x), .side_o (neg_x_d)
  );

  pes_div #(.SW(1)) u_axis_y_div (
    .clk (clk), .en (adv),
    .num_i ({2'b00, front_s6_r.mag_y, 30'd0}), .den_i (speed_s6_r),
    .side_i (front_s6_r.neg_y), .quo_o (quo_y), .side_o (neg_y_d)
  );

  pes_div #(.SW(1)) u_axis_z_div (
    .clk (clk), .en (adv),
    .num_i ({2'b00, front_s6_r.mag_z, 30'd0}), .den_i (speed_s6_r),
    .side_i (front_s6_r.neg_z), .quo_o (quo_z), .side_o (neg_z_d)
  );

  // Stage 7: volume product.
  logic [63:0]    vprod_s7_r;
  pes_pkg::back_t back_s7_r, back_out;
  logic [31:0]    minor_kv;

  always_ff @(posedge clk) begin
    if (adv) begin
      vprod_s7_r          <= 64'(vol_out.radius) * 64'(quo_v);
      back_s7_r.major     <= vol_out.major;
      back_s7_r.radius    <= vol_out.radius;
      back_s7_r.ellipsoid <= vol_out.ellipsoid;
      back_s7_r.quo_x     <= quo_x;
      back_s7_r.quo_y     <= quo_y;
      back_s7_r.quo_z     <= quo_z;
      back_s7_r.neg_x     <= neg_x_d;
      back_s7_r.neg_y     <= neg_y_d;
      back_s7_r.neg_z     <= neg_z_d;
    end
  end

  pes_sqrt #(.SW($bits(pes_pkg::back_t))) u_minor_sqrt (
    .clk    (clk),
    .en     (adv),
    .rad_i  (vprod_s7_r),
    .side_i (back_s7_r),
    .root_o (minor_kv),
    .side_o (back_out)
  );

  // Stage 8: output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (back_out.ellipsoid) begin
        out_radius_major <= back_out.major;
        out_radius_minor <= (vel_scaling_r && keep_volume_r) ? minor_kv : back_out.radius;
        out_axis_x <= back_out.neg_x ? (~back_out.quo_x + 32'd1) : back_out.quo_x;
        out_axis_y <= back_out.neg_y ? (~back_out.quo_y + 32'd1) : back_out.quo_y;
        out_axis_z <= back_out.neg_z ? (~back_out.quo_z + 32'd1) : back_out.quo_z;
        out_is_ellipsoid <= 1'b1;
      end else begin
        out_radius_major <= back_out.radius;
        out_radius_minor <= back_out.radius;
        out_axis_x       <= pes_pkg::AXIS_ONE;
        out_axis_y       <= '0;
        out_axis_z       <= '0;
        out_is_ellipsoid <= 1'b0;
      end
    end
  end

  a_sphere_shape : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_ellipsoid |->
      out_axis_x == pes_pkg::AXIS_ONE && out_axis_y == 0 && out_axis_z == 0 &&
      out_radius_major == out_radius_minor)
    else $error("sphere result has wrong axis or radii");

  a_minor_le_major : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_ellipsoid |-> out_radius_minor <= out_radius_major)
    else $error("minor radius exceeds major radius");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ----- test/tb.sv -----
// Testbench for the particle ellipsoid shape core with directed and random particles.
`timescale 1ns / 100ps

module tb;

  localparam int LATENCY = 103;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] radius;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
  } particle_t;

  typedef struct packed {
    logic [31:0] major;
    logic [31:0] minor;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic        ellip;
  } shape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_particle_radius = '0;
  logic signed [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_radius_major, out_radius_minor;
  logic signed [31:0] out_axis_x, out_axis_y, out_axis_z;
  logic out_is_ellipsoid;

  particle_ellipsoid_shape_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] scale_q, dt_q;
  logic vel_scaling_q, keep_volume_q;
  logic [63:0] min_s2_q;
  logic in_taken = 1'b0;

  particle_t pending_particles[$];
  shape_t expected_shapes[$];
  int unsigned send_idle_pct = 0, stall_pct = 0, hold_off = 0;
  int unsigned mismatches = 0, checked = 0, ellipsoids = 0, cycles = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] clamp32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] unit_comp(logic [31:0] v, logic [63:0] speed);
    logic [63:0] m, q;
    m = v[31] ? {32'd0, -v} : {32'd0, v};
    q = (m << 30) / speed;
    return v[31] ? -q[31:0] : q[31:0];
  endfunction

  function automatic shape_t predict_shape(particle_t p);
    shape_t s;
    logic [63:0] r, mx, my, mz, s2, speed, maj, q;
    r = clamp32(({32'd0, p.radius} * {32'd0, scale_q}) >> 16);
    mx = p.vx[31] ? {32'd0, -p.vx} : {32'd0, p.vx};
    my = p.vy[31] ? {32'd0, -p.vy} : {32'd0, p.vy};
    mz = p.vz[31] ? {32'd0, -p.vz} : {32'd0, p.vz};
    s2 = mx * mx + my * my + mz * mz;
    if (s2 > min_s2_q) begin
      speed = int_sqrt(s2);
      s.ax = unit_comp(p.vx, speed);
      s.ay = unit_comp(p.vy, speed);
      s.az = unit_comp(p.vz, speed);
      s.ellip = 1'b1;
      if (vel_scaling_q) begin
        maj = clamp32(r + (({32'd0, dt_q} * speed) >> 17));
        s.major = maj[31:0];
        if (keep_volume_q && maj != 0) begin
          q = (r * r) / maj;
          s.minor = clamp32(int_sqrt(r * q));
        end else if (keep_volume_q) begin
          s.minor = '0;
        end else begin
          s.minor = r[31:0];
        end
      end else begin
        s.major = clamp32(r * 3);
        s.minor = r[31:0];
      end
    end else begin
      s.ax = pes_pkg::AXIS_ONE;
      s.ay = '0;
      s.az = '0;
      s.ellip = 1'b0;
      s.major = r[31:0];
      s.minor = r[31:0];
    end
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Input side: an accepted transaction is recorded at the rising edge.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_shapes.push_back(predict_shape({in_particle_radius, in_vel_x, in_vel_y,
                                               in_vel_z}));
    end
  end

  // Driver: presents the next particle once the current one has been taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_particles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          particle_t p;
          p = pending_particles.pop_front();
          in_valid <= 1'b1;
          in_particle_radius <= p.radius;
          in_vel_x <= p.vx;
          in_vel_y <= p.vy;
          in_vel_z <= p.vz;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted down here.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (expected_shapes.size() == 0) begin
        report_mismatch("unexpected result", out_radius_major, 0);
      end else begin
        shape_t e;
        e = expected_shapes.pop_front();
        checked++;
        if (e.ellip) ellipsoids++;
        if (out_radius_major !== e.major)
          report_mismatch("radius_major", out_radius_major, e.major);
        if (out_radius_minor !== e.minor)
          report_mismatch("radius_minor", out_radius_minor, e.minor);
        if (out_axis_x !== e.ax) report_mismatch("axis_x", out_axis_x, e.ax);
        if (out_axis_y !== e.ay) report_mismatch("axis_y", out_axis_y, e.ay);
        if (out_axis_z !== e.az) report_mismatch("axis_z", out_axis_z, e.az);
        if (out_is_ellipsoid !== e.ellip)
          report_mismatch("is_ellipsoid", out_is_ellipsoid, e.ellip);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_shapes.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(pes_pkg::cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pes_pkg::REG_RADIUS_SCALE: scale_q = val[31:0];
      pes_pkg::REG_TIME_STEP:    dt_q = val[31:0];
      pes_pkg::REG_VEL_SCALING:  vel_scaling_q = val[0];
      pes_pkg::REG_KEEP_VOLUME:  keep_volume_q = val[0];
      pes_pkg::REG_MIN_SPEED_SQ: min_s2_q = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_particles.size() > 0 || in_valid || expected_shapes.size() > 0)
      @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(4))
      0: return $urandom();
      1: return $urandom_range(255) - 128;
      2: return {{16{1'b0}}, 16'($urandom())} ^ {32{1'($urandom())}};
      3: return 32'h8000_0000 | $urandom_range(3);
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  function automatic logic [31:0] rand_radius();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h0004_0000);
      2: return $urandom_range(3) == 0 ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  task automatic queue_random(int n);
    repeat (n)
      pending_particles.push_back({rand_radius(), rand_vel(), rand_vel(), rand_vel()});
  endtask

  initial begin
    scale_q = 32'd65536;
    dt_q = 0;
    vel_scaling_q = 1'b1;
    keep_volume_q = 1'b0;
    min_s2_q = 64'd43;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, threshold edges, sphere and both ellipsoid modes.
    pending_particles.push_back({32'h0, 32'h0, 32'h0, 32'h0});
    pending_particles.push_back({32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000});
    pending_particles.push_back({32'h0001_0000, 32'h8000_0000, 32'h0, 32'h0});
    pending_particles.push_back({32'h0001_0000, 32'd6, 32'd2, 32'd3});
    pending_particles.push_back({32'h0001_0000, 32'd6, 32'd2, 32'd4});
    pending_particles.push_back({32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0});
    pending_particles.push_back({32'h0002_0000, 32'hFFFF_FFFF, 32'd0, 32'd1});
    drain();
    write_reg(pes_pkg::REG_TIME_STEP, 64'hFFFF_FFFF);
    write_reg(pes_pkg::REG_KEEP_VOLUME, 64'd1);
    write_reg(pes_pkg::REG_RADIUS_SCALE, 64'hFFFF_FFFF);
    write_reg(pes_pkg::REG_MIN_SPEED_SQ, 64'd0);
    pending_particles.push_back({32'h0, 32'd1, 32'd0, 32'd0});
    pending_particles.push_back({32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_particles.push_back({32'h0000_0001, 32'h0001_0000, 32'h0, 32'h0});
    pending_particles.push_back({32'h0003_0000, 32'h8000_0000, 32'h8000_0000, 32'h0});
    drain();
    write_reg(pes_pkg::REG_VEL_SCALING, 64'd0);
    pending_particles.push_back({32'hFFFF_FFFF, 32'd5, 32'd0, 32'd0});
    pending_particles.push_back({32'h0001_0000, 32'hFFFF_FFFB, 32'd7, 32'd0});
    drain();
    write_reg(pes_pkg::REG_MIN_SPEED_SQ, 64'hFFFF_FFFF_FFFF_FFFF);
    pending_particles.push_back({32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    drain();

    // Random phases across register settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(pes_pkg::REG_RADIUS_SCALE,
                ph == 0 ? 64'd0 : (ph[0] ? 64'd65536 : 64'($urandom())));
      write_reg(pes_pkg::REG_TIME_STEP,
                ph == 1 ? 64'd0 : 64'($urandom() >> $urandom_range(31)));
      write_reg(pes_pkg::REG_VEL_SCALING, 64'(ph != 2));
      write_reg(pes_pkg::REG_KEEP_VOLUME, 64'(ph[0] | ph[2]));
      write_reg(pes_pkg::REG_MIN_SPEED_SQ,
                ph == 3 ? 64'd0 : 64'($urandom()) << $urandom_range(20));
      send_idle_pct = (ph % 4 == 1) ? 59 : (ph % 4 == 3) ? 28 : 0;
      stall_pct = (ph % 4 == 2) ? 59 : (ph % 4 == 3) ? 28 : 0;
      if (ph == 4) hold_off = 400;
      queue_random(240);
      drain();
    end

    $display("Checked %0d shapes (%0d ellipsoids) over 8 register settings,",
             checked, ellipsoids);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (mismatches == 0 && expected_shapes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/pes_pkg.sv
src/pes_sqrt.sv
src/pes_div.sv
src/particle_ellipsoid_shape_core.sv
test/tb.sv
